// File: hw/rtl/ats_pkg.sv
// Package for the adaptive tile subsampler: constants, codes and beat types.
// No dependencies; every other file of the block imports it.
package ats_pkg;

  localparam int unsigned TILE_SIZE   = 16;
  localparam int unsigned STACK_DEPTH = 16;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned SIZE_W  = 6;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned KNOWN_W = 3;
  localparam int unsigned CI_W    = 3;
  localparam int unsigned CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W   = $clog2(STACK_DEPTH);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COLOR_W-1:0] MASK_RESET     = 16'he79c;
  localparam logic [SIZE_W-1:0]  STOP_SIZE_HALF = 6'd4;
  localparam logic [SIZE_W-1:0]  STOP_SIZE_FULL = 6'd2;
  localparam logic [CI_W-1:0]    NUM_CORNERS    = 3'd4;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } ats_op_e;

  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_FILL    = 1'b1
  } ats_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMPARE_MASK = 1'b0,
    REG_HALF_RES     = 1'b1
  } ats_reg_e;

  typedef struct packed {
    ats_op_e              operation;
    logic [POS_W-1:0]     tile_x;
    logic [POS_W-1:0]     tile_y;
    logic [COLOR_W-1:0]   sample_color;
  } ats_in_t;

  typedef struct packed {
    ats_kind_e            kind;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [SIZE_W-1:0]    fill_size;
    logic [COLOR_W-1:0]   fill_color;
    logic                 tile_done;
    logic                 last;
  } ats_out_t;

  // Tile being sampled; known is 0 for none, k+1 for corner k inherited.
  typedef struct packed {
    logic [POS_W-1:0]     x;
    logic [POS_W-1:0]     y;
    logic [SIZE_W-1:0]    size;
    logic [KNOWN_W-1:0]   known;
  } ats_tile_t;

  // Stacked child tile with the parent corner colour it shares.
  typedef struct packed {
    logic [POS_W-1:0]     x;
    logic [POS_W-1:0]     y;
    logic [SIZE_W-1:0]    size;
    logic [1:0]           ki;
    logic [COLOR_W-1:0]   color;
  } ats_entry_t;

  // Burst of beats caused by one item: optional four fills, optional request.
  typedef struct packed {
    logic                      valid;
    logic                      fills;
    logic                      req;
    logic                      done;
    logic [POS_W-1:0]          req_x;
    logic [POS_W-1:0]          req_y;
    logic [POS_W-1:0]          fx0;
    logic [POS_W-1:0]          fx1;
    logic [POS_W-1:0]          fy0;
    logic [POS_W-1:0]          fy1;
    logic [SIZE_W-1:0]         hsz;
    logic [3:0][COLOR_W-1:0]   cols;
  } ats_burst_t;

endpackage

// File: hw/rtl/ats_in_buf.sv
// Input register of the adaptive tile subsampler: holds one accepted beat.
// Depends on ats_pkg.
module ats_in_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ats_pkg::ats_in_t in_data_i,
  input  logic            take_i,
  output logic            vld_o,
  output ats_pkg::ats_in_t item_o
);
  import ats_pkg::*;

  logic    vld_q, vld_d;
  ats_in_t item_q, item_d;
  logic    accept;

  assign in_stall_o = vld_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d  = (vld_q & ~take_i) | accept;
    item_d = accept ? in_data_i : item_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;
endmodule

// File: hw/rtl/ats_core.sv
// Tile state, child stack and per-item decision of the adaptive tile subsampler.
// Depends on ats_pkg; produces one burst descriptor per taken item.
module ats_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ats_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ats_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               take_i,
  input  ats_pkg::ats_in_t                   item_i,
  output ats_pkg::ats_burst_t                burst_o
);
  import ats_pkg::*;

  logic [COLOR_W-1:0]         mask_q;
  logic                       half_q;
  logic                       busy_q, busy_d;
  logic [CNT_W-1:0]           count_q, count_d;
  ats_tile_t                  tile_q, tile_d;
  logic [3:0][COLOR_W-1:0]    cols_q, cols_d;
  logic [CI_W-1:0]            ci_q, ci_d;
  ats_entry_t                 stack_q [STACK_DEPTH];

  logic                       push_we;
  ats_entry_t                 child [3];
  logic [IDX_W-1:0]           push_idx [3];

  logic [POS_W-1:0]           x1, y1, xm, ym;
  logic [SIZE_W-1:0]          hsz;
  logic [CI_W-1:0]            ci_a, ci_b;
  logic [3:0][COLOR_W-1:0]    cols_n;
  logic                       stop, same, full;
  ats_entry_t                 top;
  logic [POS_W-1:0]           px1;
  logic [COLOR_W-1:0]         ref_col;

  always_comb begin
    x1  = tile_q.x + (POS_W'(tile_q.size) - POS_W'(1));
    y1  = tile_q.y + (POS_W'(tile_q.size) - POS_W'(1));
    hsz = tile_q.size >> 1;
    xm  = tile_q.x + POS_W'(hsz);
    ym  = tile_q.y + POS_W'(hsz);

    ci_a = ci_q + CI_W'(1);
    ci_b = (tile_q.known == KNOWN_W'(ci_a + CI_W'(1))) ? ci_a + CI_W'(1) : ci_a;

    cols_n = cols_q;
    if (ci_q < NUM_CORNERS) begin
      cols_n[ci_q[1:0]] = item_i.sample_color;
    end

    stop    = half_q ? (tile_q.size <= STOP_SIZE_HALF) : (tile_q.size <= STOP_SIZE_FULL);
    ref_col = cols_n[0] & mask_q;
    same    = ((cols_n[1] & mask_q) == ref_col) && ((cols_n[2] & mask_q) == ref_col) &&
              ((cols_n[3] & mask_q) == ref_col);
    full    = ((CNT_W+1)'(count_q) + (CNT_W+1)'(4)) > (CNT_W+1)'(STACK_DEPTH);

    top = stack_q[IDX_W'(count_q - CNT_W'(1))];
    px1 = top.x + (POS_W'(top.size) - POS_W'(1));

    for (int k = 0; k < 3; k++) begin
      child[k].x     = k[0] ? xm : tile_q.x;
      child[k].y     = k[1] ? ym : tile_q.y;
      child[k].size  = hsz;
      child[k].ki    = 2'(k);
      child[k].color = cols_n[k];
      push_idx[k]    = IDX_W'(count_q + CNT_W'(k));
    end

    busy_d  = busy_q;
    count_d = count_q;
    tile_d  = tile_q;
    cols_d  = cols_q;
    ci_d    = ci_q;
    push_we = 1'b0;

    burst_o       = '0;
    burst_o.fx0   = tile_q.x;
    burst_o.fx1   = xm;
    burst_o.fy0   = tile_q.y;
    burst_o.fy1   = ym;
    burst_o.hsz   = hsz;
    burst_o.cols  = cols_n;
    burst_o.done  = (count_q == '0);

    unique case (item_i.operation)
      OP_START: begin
        if (!busy_q) begin
          busy_d        = 1'b1;
          count_d       = '0;
          tile_d.x      = item_i.tile_x;
          tile_d.y      = item_i.tile_y;
          tile_d.size   = SIZE_W'(TILE_SIZE);
          tile_d.known  = '0;
          ci_d          = '0;
          burst_o.valid = 1'b1;
          burst_o.req   = 1'b1;
          burst_o.req_x = item_i.tile_x;
          burst_o.req_y = item_i.tile_y;
        end
      end
      OP_SAMPLE: begin
        if (busy_q) begin
          cols_d        = cols_n;
          ci_d          = ci_b;
          burst_o.valid = 1'b1;
          if (ci_b < NUM_CORNERS) begin
            // next missing corner of the current tile
            burst_o.req   = 1'b1;
            burst_o.req_x = ci_b[0] ? x1 : tile_q.x;
            burst_o.req_y = ci_b[1] ? y1 : tile_q.y;
          end else if (stop || same || full) begin
            burst_o.fills = 1'b1;
            if (count_q == '0) begin
              busy_d = 1'b0;
            end else begin
              // pop: the inherited corner skips its request
              count_d          = count_q - CNT_W'(1);
              tile_d.x         = top.x;
              tile_d.y         = top.y;
              tile_d.size      = top.size;
              tile_d.known     = KNOWN_W'(top.ki) + KNOWN_W'(1);
              cols_d[top.ki]   = top.color;
              ci_d             = (top.ki == 2'd0) ? CI_W'(1) : CI_W'(0);
              burst_o.req      = 1'b1;
              burst_o.req_x    = (top.ki == 2'd0) ? px1 : top.x;
              burst_o.req_y    = top.y;
            end
          end else begin
            // split: push three children, bottom-right child goes straight in
            push_we       = 1'b1;
            count_d       = count_q + CNT_W'(3);
            tile_d.x      = xm;
            tile_d.y      = ym;
            tile_d.size   = hsz;
            tile_d.known  = KNOWN_W'(4);
            ci_d          = '0;
            burst_o.req   = 1'b1;
            burst_o.req_x = xm;
            burst_o.req_y = ym;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= MASK_RESET;
      half_q  <= 1'b1;
      busy_q  <= 1'b0;
      count_q <= '0;
      tile_q  <= '0;
      cols_q  <= '0;
      ci_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_COMPARE_MASK: mask_q <= cfg_data_i[COLOR_W-1:0];
          REG_HALF_RES:     half_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (take_i) begin
        busy_q  <= busy_d;
        count_q <= count_d;
        tile_q  <= tile_d;
        cols_q  <= cols_d;
        ci_q    <= ci_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (take_i && push_we && push_idx[k] == IDX_W'(i)) begin
          stack_q[i] <= child[k];
        end
      end
    end
  end
endmodule

// File: hw/rtl/ats_burst.sv
// Result register of the adaptive tile subsampler: plays out one burst as beats.
// Depends on ats_pkg; takes burst descriptors from ats_core.
module ats_burst (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  ats_pkg::ats_burst_t  burst_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ats_pkg::ats_out_t    out_data_o
);
  import ats_pkg::*;

  ats_burst_t  desc_q;
  logic        vld_q, vld_d;
  logic [2:0]  beat_q, beat_d;
  logic        is_fill, is_last, fire;
  logic [2:0]  last_idx;

  always_comb begin
    is_fill  = desc_q.fills && !beat_q[2];
    last_idx = desc_q.fills ? (desc_q.req ? 3'd4 : 3'd3) : 3'd0;
    is_last  = (beat_q == last_idx);
    fire     = vld_q && !out_stall_i;
    can_load_o = !vld_q || (fire && is_last);

    out_data_o.kind       = is_fill ? KIND_FILL : KIND_REQUEST;
    out_data_o.pos_x      = is_fill ? (beat_q[0] ? desc_q.fx1 : desc_q.fx0) : desc_q.req_x;
    out_data_o.pos_y      = is_fill ? (beat_q[1] ? desc_q.fy1 : desc_q.fy0) : desc_q.req_y;
    out_data_o.fill_size  = is_fill ? desc_q.hsz : '0;
    out_data_o.fill_color = is_fill ? desc_q.cols[beat_q[1:0]] : '0;
    out_data_o.tile_done  = is_fill && desc_q.done && (beat_q == 3'd3);
    out_data_o.last       = is_last;

    vld_d  = vld_q;
    beat_d = beat_q;
    if (load_i) begin
      vld_d  = burst_i.valid;
      beat_d = '0;
    end else if (fire && is_last) begin
      vld_d = 1'b0;
    end else if (fire) begin
      beat_d = beat_q + 3'd1;
    end
  end

  assign out_valid_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beat_q <= '0;
    end else begin
      vld_q  <= vld_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= burst_i;
    end
  end
endmodule

// File: hw/rtl/adaptive_tile_subsampler.sv
// Top level of the adaptive tile subsampler: input register, tile core, beat emitter.
// Depends on ats_pkg, ats_in_buf, ats_core and ats_burst.
//
// A start beat opens a 16-pixel tile; the block answers with sample requests for
// the corners it lacks, and each sample beat returns the colour of the last
// request. Once a tile has all four corners it is either filled as four quadrants
// (corners agree under compare_mask, stop size reached, or fewer than four stack
// entries free) or split into four children, three of them pushed on a 16-entry
// stack. A start gives one result beat; a sample gives one (request), four (final
// fills, with tile_done on the fourth) or five (fills, then the request of the next
// stacked tile). Each item is decided from the input register once the result
// register can take its burst; a burst is loaded into an empty result register or
// as the last beat of the previous burst leaves. Results leave the result register
// one beat per cycle unless out_stall_i holds them, while the next item waits in the
// input register. Start while busy and sample while idle are dropped without results.
// Write the configuration registers only while idle.
module adaptive_tile_subsampler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ats_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ats_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ats_pkg::ats_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ats_pkg::ats_out_t               out_data_o
);
  import ats_pkg::*;

  logic       item_vld;
  ats_in_t    item;
  logic       can_load;
  logic       take;
  ats_burst_t burst;

  // an item is decided only when the result register can take its burst
  assign take = item_vld & can_load;

  ats_in_buf u_in_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .vld_o      (item_vld),
    .item_o     (item)
  );

  ats_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .item_i     (item),
    .burst_o    (burst)
  );

  ats_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .burst_i     (burst),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );
endmodule

// File: bench/tb_adaptive_tile_subsampler.sv
`timescale 1ns / 1ps
// Self-checking bench for adaptive_tile_subsampler: directed table, then random tiles.
// Depends on ats_pkg and the RTL of the block; keeps its own quadtree predictor.
module tb_adaptive_tile_subsampler;
  import ats_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 16;   // covers the decide cycle of dropped beats
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned HOLD_AFTER     = 60;   // output beats seen before the long hold
  localparam int unsigned PHASE_ITEMS    = 45;
  localparam int unsigned NUM_PHASES     = 5;

  // How a directed row is checked: by the predictor, no beat at all, or one typed beat.
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_ONE
  } row_check_e;

  typedef struct packed {
    ats_in_t    beat;
    row_check_e chk;
    ats_out_t   gold;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  ats_in_t   in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  ats_out_t  out_data_o;

  adaptive_tile_subsampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Predictor state: a private copy of the block's tile walker and registers.
  logic                  p_busy;
  ats_entry_t            tile_stack [STACK_DEPTH];
  logic [CNT_W-1:0]      stack_fill;
  ats_tile_t             cur_tile;
  logic [COLOR_W-1:0]    corner_col [4];
  logic [CI_W-1:0]       next_corner;
  logic [COLOR_W-1:0]    cmp_mask;
  logic                  half_res;

  ats_out_t owed_beats [$];    // beats the block still owes, oldest first
  int       mismatches;
  int       beats_out;
  int       burst_left;
  int       idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic ats_out_t make_beat(ats_kind_e kind, logic [POS_W-1:0] x,
                                         logic [POS_W-1:0] y, logic [SIZE_W-1:0] size,
                                         logic [COLOR_W-1:0] color, logic done);
    ats_out_t r;
    r.kind       = kind;
    r.pos_x      = x;
    r.pos_y      = y;
    r.fill_size  = size;
    r.fill_color = color;
    r.tile_done  = done;
    r.last       = 1'b0;
    return r;
  endfunction

  // A lone sample request, as a start or a mid-tile sample produces.
  function automatic ats_out_t gold_req(int x, int y);
    ats_out_t r;
    r = make_beat(KIND_REQUEST, POS_W'(x), POS_W'(y), '0, '0, 1'b0);
    r.last = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t mk_row(ats_op_e op, int x, int y, int color,
                                       row_check_e chk, ats_out_t gold);
    stim_row_t r;
    r.beat.operation    = op;
    r.beat.tile_x       = POS_W'(x);
    r.beat.tile_y       = POS_W'(y);
    r.beat.sample_color = COLOR_W'(color);
    r.chk  = chk;
    r.gold = gold;
    return r;
  endfunction

  // Walks the quadtree until a sample is needed or the started tile is finished.
  task automatic descend_tile(ref ats_out_t res[$]);
    logic [POS_W-1:0]   x1, y1;
    logic [SIZE_W-1:0]  half_sz;
    logic [COLOR_W-1:0] base;
    logic               stop, agree, tail;
    ats_entry_t         ent;
    forever begin
      x1 = cur_tile.x + POS_W'(cur_tile.size) - POS_W'(1);
      y1 = cur_tile.y + POS_W'(cur_tile.size) - POS_W'(1);
      half_sz = cur_tile.size >> 1;
      // skip the corner inherited from the parent
      while (next_corner < NUM_CORNERS && cur_tile.known == next_corner + 3'd1)
        next_corner++;
      if (next_corner < NUM_CORNERS) begin
        res.push_back(make_beat(KIND_REQUEST, next_corner[0] ? x1 : cur_tile.x,
                                next_corner[1] ? y1 : cur_tile.y, '0, '0, 1'b0));
        return;
      end
      stop  = half_res ? (cur_tile.size <= STOP_SIZE_HALF) : (cur_tile.size <= STOP_SIZE_FULL);
      base  = corner_col[0] & cmp_mask;
      agree = (corner_col[1] & cmp_mask) == base && (corner_col[2] & cmp_mask) == base &&
              (corner_col[3] & cmp_mask) == base;
      if (stop || agree || int'(stack_fill) + 4 > STACK_DEPTH) begin
        tail = (stack_fill == 0);
        for (int k = 0; k < 4; k++)
          res.push_back(make_beat(KIND_FILL, cur_tile.x + POS_W'(k[0] ? half_sz : 6'd0),
                                  cur_tile.y + POS_W'(k[1] ? half_sz : 6'd0), half_sz,
                                  corner_col[k], tail && k == 3));
        if (tail) begin
          p_busy = 1'b0;
          return;
        end
      end else begin
        for (int k = 0; k < 4; k++) begin
          tile_stack[stack_fill[IDX_W-1:0]] = '{x: cur_tile.x + POS_W'(k[0] ? half_sz : 6'd0),
                                     y: cur_tile.y + POS_W'(k[1] ? half_sz : 6'd0),
                                     size: half_sz, ki: 2'(k), color: corner_col[k]};
          stack_fill++;
        end
      end
      // pop: the child brings back the parent colour of its shared corner
      stack_fill--;
      ent = tile_stack[stack_fill[IDX_W-1:0]];
      cur_tile = '{x: ent.x, y: ent.y, size: ent.size, known: KNOWN_W'(ent.ki) + 3'd1};
      next_corner = '0;
      corner_col[ent.ki] = ent.color;
    end
  endtask

  task automatic predict_tile_beats(input ats_in_t b, ref ats_out_t res[$]);
    res = {};
    if (b.operation == OP_START) begin
      if (p_busy) return;          // start while busy: dropped
      p_busy      = 1'b1;
      stack_fill  = '0;
      cur_tile    = '{x: b.tile_x, y: b.tile_y, size: SIZE_W'(TILE_SIZE), known: '0};
      next_corner = '0;
    end else begin
      if (!p_busy) return;         // sample while idle: dropped
      if (next_corner < NUM_CORNERS) corner_col[next_corner[1:0]] = b.sample_color;
      next_corner++;
    end
    descend_tile(res);
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endtask

  // Offers one input beat, held until accepted; the sender works in bursts with gaps.
  task automatic send_beat(input ats_in_t b, input row_check_e chk, input ats_out_t gold,
                           output int produced);
    ats_out_t res [$];
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_tile_beats(b, res);
    produced = res.size();
    if (chk == CHK_NONE) res = {};
    else if (chk == CHK_ONE) res = '{gold};
    foreach (res[i]) owed_beats.push_back(res[i]);
  endtask

  // Waits until every owed beat has come, then lets a dropped beat drain through.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(ats_reg_e idx, logic [COLOR_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_COMPARE_MASK: cmp_mask = val;
      REG_HALF_RES:     half_res = val[0];
      default: ;
    endcase
  endtask

  task automatic check_field(string name, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Stimulus: reset, directed table, then random phases under several settings.
  initial begin
    stim_row_t          dir_rows [$];
    ats_in_t            b;
    ats_out_t           none;
    int                 produced, items, pick;
    logic [COLOR_W-1:0] tile_base;
    logic [COLOR_W-1:0] ph_mask [NUM_PHASES];
    logic               ph_half [NUM_PHASES];

    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_COMPARE_MASK;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    none        = '0;
    mismatches  = 0;
    burst_left  = 0;
    tile_base   = '0;
    p_busy      = 1'b0;
    stack_fill  = '0;
    cur_tile    = '0;
    next_corner = '0;
    foreach (corner_col[i]) corner_col[i] = '0;
    cmp_mask    = MASK_RESET;
    half_res    = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, reset settings. Colours 0x0863/0x1803/0x0060 differ only in
    // bits outside the reset mask, so the first tile fills at once.
    dir_rows.push_back(mk_row(OP_SAMPLE, 4095, 4095, 16'hffff, CHK_NONE, none)); // idle sample
    dir_rows.push_back(mk_row(OP_START,  0,    0,    0,        CHK_ONE, gold_req(0, 0)));
    dir_rows.push_back(mk_row(OP_START,  4095, 4095, 16'hffff, CHK_NONE, none)); // busy start
    dir_rows.push_back(mk_row(OP_SAMPLE, 0, 0, 16'h0000, CHK_ONE, gold_req(15, 0)));
    dir_rows.push_back(mk_row(OP_SAMPLE, 0, 0, 16'h0863, CHK_ONE, gold_req(0, 15)));
    dir_rows.push_back(mk_row(OP_SAMPLE, 0, 0, 16'h1803, CHK_ONE, gold_req(15, 15)));
    dir_rows.push_back(mk_row(OP_SAMPLE, 0, 0, 16'h0060, CHK_PREDICT, none));
    // far corner: request positions wrap past 4095
    dir_rows.push_back(mk_row(OP_START,  4095, 4095, 0, CHK_ONE, gold_req(4095, 4095)));
    dir_rows.push_back(mk_row(OP_SAMPLE, 0, 0, 16'hffff, CHK_ONE, gold_req(14, 4095)));
    dir_rows.push_back(mk_row(OP_SAMPLE, 0, 0, 16'h0000, CHK_ONE, gold_req(4095, 14)));
    dir_rows.push_back(mk_row(OP_SAMPLE, 0, 0, 16'hffff, CHK_ONE, gold_req(14, 14)));
    // corners disagree: split, then each child agrees with its inherited corner
    dir_rows.push_back(mk_row(OP_SAMPLE, 0, 0, 16'h0000, CHK_PREDICT, none));
    for (int c = 0; c < 12; c++)
      dir_rows.push_back(mk_row(OP_SAMPLE, 4095, 0, (c / 3) % 2 ? 16'hffff : 16'h0000,
                                CHK_PREDICT, none));

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].chk, dir_rows[i].gold,
                                    produced);
    drain_and_settle();

    ph_mask = '{16'hffff, 16'h0000, 16'hffff, COLOR_W'($urandom), COLOR_W'($urandom)};
    ph_half = '{1'b0, 1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1))};

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_COMPARE_MASK, ph_mask[ph]);
      write_reg(REG_HALF_RES, COLOR_W'(ph_half[ph]));
      cfg_we_i <= 1'b0;
      @(posedge clk_i);

      items = 0;
      while (items < PHASE_ITEMS) begin
        b.tile_x       = POS_W'($urandom_range(0, 4095));
        b.tile_y       = POS_W'($urandom_range(0, 4095));
        b.sample_color = COLOR_W'($urandom);
        // mostly well-formed: sample while a tile is open, start when idle
        if (p_busy ^ ($urandom_range(0, 9) == 0)) begin
          b.operation = OP_SAMPLE;
          pick = $urandom_range(0, 9);
          if (pick < 5)      b.sample_color = tile_base;
          else if (pick < 8) b.sample_color = tile_base ^ (16'h1 << $urandom_range(0, 15));
        end else begin
          b.operation = OP_START;
          tile_base   = COLOR_W'($urandom);
        end
        send_beat(b, CHK_PREDICT, none, produced);
        if (produced > 0) items++;
      end
      // close the open tile so the next register write finds the block idle;
      // matching the inherited corner lets each stacked child fill at once
      while (p_busy) begin
        b.operation    = OP_SAMPLE;
        b.sample_color = (cur_tile.known != '0) ?
                         corner_col[cur_tile.known[1:0] - 2'd1] : tile_base;
        send_beat(b, CHK_PREDICT, none, produced);
      end
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver stall pattern; once, a long hold-off so the block backs up onto its input.
  initial begin
    int mode, span;
    bit held_long;
    held_long = 1'b0;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 9);
      span = $urandom_range(5, 60);
      if (!held_long && beats_out >= HOLD_AFTER) begin
        held_long = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        for (int c = 0; c < span; c++) begin
          if (mode < 3)      out_stall_i <= 1'b0;
          else if (mode < 7) out_stall_i <= 1'($urandom_range(0, 1));
          else if (mode < 9) out_stall_i <= (c % 3 == 0);
          else               out_stall_i <= ($urandom_range(0, 3) != 0);
          @(posedge clk_i);
        end
      end
    end
  end

  // Result checker: each accepted beat against the oldest owed beat.
  initial beats_out = 0;
  always @(posedge clk_i) begin
    ats_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (owed_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = owed_beats.pop_front();
        check_field("kind",       COLOR_W'(want.kind),      COLOR_W'(out_data_o.kind));
        check_field("pos_x",      COLOR_W'(want.pos_x),     COLOR_W'(out_data_o.pos_x));
        check_field("pos_y",      COLOR_W'(want.pos_y),     COLOR_W'(out_data_o.pos_y));
        check_field("fill_size",  COLOR_W'(want.fill_size), COLOR_W'(out_data_o.fill_size));
        check_field("fill_color", want.fill_color,          out_data_o.fill_color);
        check_field("tile_done",  COLOR_W'(want.tile_done), COLOR_W'(out_data_o.tile_done));
        check_field("last",       COLOR_W'(want.last),      COLOR_W'(out_data_o.last));
      end
    end
  end

  // Watchdog: too long without any beat or register write means the block hung.
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
